FILE: src/cpbp_pkg.sv
package cpbp_pkg;

    localparam int BUF_BITS = 256;
    localparam int WORD_W   = 64;
    localparam int CUR_W    = 9;
    localparam int VAL_W    = 34;
    localparam int LEN_W    = 6;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 72;

    typedef enum logic [1:0] {
        FUNC_HEADER  = 2'd0,
        FUNC_SQUARE  = 2'd1,
        FUNC_TRAILER = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        PT_EMPTY  = 3'd0,
        PT_PAWN   = 3'd1,
        PT_KNIGHT = 3'd2,
        PT_BISHOP = 3'd3,
        PT_ROOK   = 3'd4,
        PT_QUEEN  = 3'd5,
        PT_KING   = 3'd6,
        PT_SPARE  = 3'd7
    } piece_t;

    typedef struct packed {
        logic [15:0] fullmove;
        logic [6:0]  fifty_count;
        logic [5:0]  ep_square;
        logic        ep_valid;
        logic [3:0]  castle_rights;
        logic        piece_color;
        logic [2:0]  piece_kind;
        logic [5:0]  black_king_square;
        logic [5:0]  white_king_square;
        logic        side_to_move;
    } item_t;

    function automatic logic [3:0] piece_code(input logic [2:0] pt);
        logic [3:0] code;
        case (pt)
            PT_PAWN:   code = 4'b0001;
            PT_KNIGHT: code = 4'b0011;
            PT_BISHOP: code = 4'b0101;
            PT_ROOK:   code = 4'b0111;
            PT_QUEEN:  code = 4'b1001;
            default:   code = 4'b0000;
        endcase
        return code;
    endfunction

endpackage

FILE: src/chess_position_bit_packer_core.sv
// a trailer passes the input register, then the snapshot register presents its first word
// throughput: one item per cycle unless a trailer stalls; 4 words out, one per ready cycle
// a following trailer waits in the input register until the previous fourth word is taken
// header and square items give no output; they only update the working buffer
// reset (aresetn low, synchronous) clears buffer, cursor, overflow flag and all valid state
module chess_position_bit_packer_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // side_to_move, white_king_square, black_king_square, piece_kind, piece_color,
    // castle_rights, ep_valid, ep_square, fifty_count, fullmove, zero pad
    input  logic [cpbp_pkg::IN_W-1:0] s_tdata,
    // func
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // word_index, packed_word, zero pad
    output logic [cpbp_pkg::OUT_W-1:0] m_tdata,
    // overflow
    output logic                      m_tuser,
    output logic                      m_tlast
);

    logic                          in_valid_reg;
    cpbp_pkg::item_t               in_item_reg;
    cpbp_pkg::func_t               in_func_reg;

    logic [cpbp_pkg::BUF_BITS-1:0] buf_reg, buf_next;
    logic [cpbp_pkg::CUR_W-1:0]    cursor_reg, cursor_next;
    logic                          ovf_reg, ovf_next;

    logic [cpbp_pkg::BUF_BITS-1:0] snap_reg;
    logic                          snap_ovf_reg;
    logic                          out_valid_reg;
    logic [1:0]                    out_idx_reg;

    logic                          snap_free;
    logic                          take_item;
    logic                          is_trailer;

    logic [cpbp_pkg::VAL_W-1:0]    val;
    logic [cpbp_pkg::LEN_W-1:0]    len;
    logic [cpbp_pkg::BUF_BITS-1:0] base_buf;
    logic [cpbp_pkg::CUR_W-1:0]    base_cursor;
    logic                          base_ovf;
    logic [cpbp_pkg::BUF_BITS+cpbp_pkg::VAL_W-1:0] ins;
    logic [cpbp_pkg::CUR_W:0]      sum;
    logic [cpbp_pkg::WORD_W-1:0]   word_sel;

    assign is_trailer = (in_func_reg == cpbp_pkg::FUNC_TRAILER);
    assign snap_free  = !out_valid_reg || (m_tready && out_idx_reg == 2'd3);
    assign take_item  = in_valid_reg && (!is_trailer || snap_free);
    assign s_tready   = !in_valid_reg || take_item;

    // bits to append for the held item
    always_comb begin
        val         = '0;
        len         = '0;
        base_buf    = buf_reg;
        base_cursor = cursor_reg;
        base_ovf    = ovf_reg;
        case (in_func_reg)
            cpbp_pkg::FUNC_HEADER: begin
                base_buf    = '0;
                base_cursor = '0;
                base_ovf    = 1'b0;
                val = cpbp_pkg::VAL_W'({in_item_reg.black_king_square,
                                        in_item_reg.white_king_square,
                                        in_item_reg.side_to_move});
                len = cpbp_pkg::LEN_W'(13);
            end
            cpbp_pkg::FUNC_SQUARE: begin
                if (in_item_reg.piece_kind == cpbp_pkg::PT_EMPTY) begin
                    len = cpbp_pkg::LEN_W'(1);
                end else if (in_item_reg.piece_kind inside {[cpbp_pkg::PT_PAWN:
                                                              cpbp_pkg::PT_QUEEN]}) begin
                    val = cpbp_pkg::VAL_W'({in_item_reg.piece_color,
                                            cpbp_pkg::piece_code(in_item_reg.piece_kind)});
                    len = cpbp_pkg::LEN_W'(5);
                end
            end
            cpbp_pkg::FUNC_TRAILER: begin
                if (in_item_reg.ep_valid) begin
                    val = {in_item_reg.fifty_count[6], in_item_reg.fullmove,
                           in_item_reg.fifty_count[5:0], in_item_reg.ep_square,
                           1'b1, in_item_reg.castle_rights};
                    len = cpbp_pkg::LEN_W'(34);
                end else begin
                    val = cpbp_pkg::VAL_W'({in_item_reg.fifty_count[6], in_item_reg.fullmove,
                                            in_item_reg.fifty_count[5:0], 1'b0,
                                            in_item_reg.castle_rights});
                    len = cpbp_pkg::LEN_W'(28);
                end
            end
            default: begin
            end
        endcase
    end

    // barrel-shift insert, bits past the buffer end fall off the top
    always_comb begin
        ins         = {{cpbp_pkg::BUF_BITS{1'b0}}, val} << base_cursor;
        sum         = {1'b0, base_cursor} + (cpbp_pkg::CUR_W+1)'(len);
        buf_next    = base_buf | ins[cpbp_pkg::BUF_BITS-1:0];
        if (sum > (cpbp_pkg::CUR_W+1)'(cpbp_pkg::BUF_BITS)) begin
            cursor_next = cpbp_pkg::CUR_W'(cpbp_pkg::BUF_BITS);
            ovf_next    = 1'b1;
        end else begin
            cursor_next = sum[cpbp_pkg::CUR_W-1:0];
            ovf_next    = base_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= cpbp_pkg::item_t'(s_tdata[50:0]);
            in_func_reg <= cpbp_pkg::func_t'(s_tuser);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg    <= '0;
            cursor_reg <= '0;
            ovf_reg    <= 1'b0;
        end else if (take_item && in_func_reg != cpbp_pkg::FUNC_NONE) begin
            buf_reg    <= buf_next;
            cursor_reg <= cursor_next;
            ovf_reg    <= ovf_next;
        end
    end

    // output snapshot, sent one word per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end else if (take_item && is_trailer) begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= '0;
        end else if (out_valid_reg && m_tready) begin
            out_idx_reg <= out_idx_reg + 2'd1;
            if (out_idx_reg == 2'd3) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_item && is_trailer) begin
            snap_reg     <= buf_next;
            snap_ovf_reg <= ovf_next;
        end
    end

    always_comb begin
        case (out_idx_reg)
            2'd0:    word_sel = snap_reg[63:0];
            2'd1:    word_sel = snap_reg[127:64];
            2'd2:    word_sel = snap_reg[191:128];
            default: word_sel = snap_reg[255:192];
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, word_sel, out_idx_reg};
    assign m_tuser  = snap_ovf_reg;
    assign m_tlast  = (out_idx_reg == 2'd3);

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= cpbp_pkg::CUR_W'(cpbp_pkg::BUF_BITS))
        else $error("cursor past buffer end");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> cursor_reg == cpbp_pkg::CUR_W'(cpbp_pkg::BUF_BITS))
        else $error("overflow flagged with buffer not full");

    a_trailer_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (take_item && is_trailer) |=> (out_valid_reg && out_idx_reg == 2'd0))
        else $error("trailer did not start word output");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && is_trailer && out_valid_reg))
        else $error("input stalled without a pending trailer");

endmodule
